// ===== src/dda_lr_pkg.sv =====
// Shared types and constants of the DDA line rasterizer.
package dda_lr_pkg;

   // Fixed widths of the stream fields
   localparam int CoordW   = 6;
   localparam int ColorW   = 4;
   localparam int ReqDataW = 32;
   localparam int RspDataW = 16;

   // Queue between the front and the back
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = 1;
   localparam int QueueCntW  = 2;

   // One classified line, as it waits in the queue
   typedef struct packed {
      logic [CoordW-1:0] x_start;
      logic [CoordW-1:0] y_start;
      logic [CoordW-1:0] adx;
      logic [CoordW-1:0] ady;
      logic [CoordW-1:0] steps;
      logic              x_neg;
      logic              y_neg;
      logic [ColorW-1:0] color;
   } line_job_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

// ===== src/dda_lr_front.sv =====
// Front end: accepts line requests and classifies them into queue entries.
module dda_lr_front
   import dda_lr_pkg::*;
#(
   parameter int COORD_BITS = 6
) (
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,  // x_start, y_start, x_end, y_end, line_color
   input  queue_status_type    queue_status,
   output logic                push,
   output line_job_type        job
);

   localparam logic [CoordW-1:0] CoordMask = CoordW'((1 << COORD_BITS) - 1);

   logic [CoordW-1:0] xs;
   logic [CoordW-1:0] ys;
   logic [CoordW-1:0] xe;
   logic [CoordW-1:0] ye;
   logic [CoordW-1:0] adx;
   logic [CoordW-1:0] ady;

   // Take only the low coordinate bits
   assign xs = req_tdata[CoordW-1:0] & CoordMask;
   assign ys = req_tdata[2*CoordW-1:CoordW] & CoordMask;
   assign xe = req_tdata[3*CoordW-1:2*CoordW] & CoordMask;
   assign ye = req_tdata[4*CoordW-1:3*CoordW] & CoordMask;

   // Work out magnitudes, directions and step count
   assign adx = (xe >= xs) ? (xe - xs) : (xs - xe);
   assign ady = (ye >= ys) ? (ye - ys) : (ys - ye);

   always_comb begin
      job.x_start = xs;
      job.y_start = ys;
      job.adx     = adx;
      job.ady     = ady;
      job.steps   = (adx > ady) ? adx : ady;
      job.x_neg   = xe < xs;
      job.y_neg   = ye < ys;
      job.color   = req_tdata[4*CoordW+ColorW-1:4*CoordW];
   end

   // Accept while the queue has room
   assign req_tready = !queue_status.full;
   assign push       = req_tvalid && !queue_status.full;

endmodule

// ===== src/dda_lr_queue.sv =====
// Short queue of classified lines between the front and the back.
module dda_lr_queue
   import dda_lr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  line_job_type     push_job,
   input  logic             pop,
   output line_job_type     head_job,
   output queue_status_type status
);

   line_job_type           entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff;
   logic [QueuePtrW-1:0]   wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff;
   logic [QueuePtrW-1:0]   rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff;
   logic [QueueCntW-1:0]   count_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = count_ff == QueueCntW'(QueueDepth);
   assign status.valid = count_ff != '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign head_job     = entries_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/dda_lr_back.sv =====
// Back end: divides out increments, walks one pixel per cycle unless stalled.
module dda_lr_back
   import dda_lr_pkg::*;
#(
   parameter int COORD_BITS = 6,
   parameter int FRAC_BITS  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  queue_status_type    queue_status,
   input  line_job_type        head_job,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,
   output logic                rsp_tlast
);

   localparam int AccW  = COORD_BITS + FRAC_BITS;
   localparam int IncW  = FRAC_BITS + 2;
   localparam int LeftW = COORD_BITS + 1;
   localparam int CntW  = $clog2(AccW);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_RUN
   } state_type;

   state_type               state_ff;
   state_type               state_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [RspDataW-1:0]     rsp_data_ff;
   logic [RspDataW-1:0]     rsp_data_in;
   logic                    rsp_last_ff;
   logic                    rsp_last_in;
   logic [LeftW-1:0]        left_ff;
   logic [LeftW-1:0]        left_in;

   logic [CntW-1:0]         cnt_ff;
   logic [CntW-1:0]         cnt_in;
   logic [COORD_BITS-1:0]   steps_ff;
   logic [COORD_BITS-1:0]   steps_in;
   logic                    x_neg_ff;
   logic                    x_neg_in;
   logic                    y_neg_ff;
   logic                    y_neg_in;
   logic [COORD_BITS-1:0]   rem_x_ff;
   logic [COORD_BITS-1:0]   rem_x_in;
   logic [COORD_BITS-1:0]   rem_y_ff;
   logic [COORD_BITS-1:0]   rem_y_in;
   logic [AccW-1:0]         num_x_ff;
   logic [AccW-1:0]         num_x_in;
   logic [AccW-1:0]         num_y_ff;
   logic [AccW-1:0]         num_y_in;
   logic [AccW-1:0]         quo_x_ff;
   logic [AccW-1:0]         quo_x_in;
   logic [AccW-1:0]         quo_y_ff;
   logic [AccW-1:0]         quo_y_in;
   logic [AccW-1:0]         x_acc_ff;
   logic [AccW-1:0]         x_acc_in;
   logic [AccW-1:0]         y_acc_ff;
   logic [AccW-1:0]         y_acc_in;
   logic [IncW-1:0]         x_inc_ff;
   logic [IncW-1:0]         x_inc_in;
   logic [IncW-1:0]         y_inc_ff;
   logic [IncW-1:0]         y_inc_in;
   logic [ColorW-1:0]       color_ff;
   logic [ColorW-1:0]       color_in;

   logic [COORD_BITS:0]     divisor;
   logic [COORD_BITS:0]     rem_sh_x;
   logic [COORD_BITS:0]     rem_sh_y;
   logic [COORD_BITS:0]     rem_sub_x;
   logic [COORD_BITS:0]     rem_sub_y;
   logic                    ge_x;
   logic                    ge_y;
   logic [AccW-1:0]         quo_next_x;
   logic [AccW-1:0]         quo_next_y;
   logic                    out_free;
   logic [CoordW-1:0]       pix_x;
   logic [CoordW-1:0]       pix_y;

   // One restoring division step for each axis, sharing the divisor
   assign divisor    = {1'b0, steps_ff};
   assign rem_sh_x   = {rem_x_ff, num_x_ff[AccW-1]};
   assign rem_sh_y   = {rem_y_ff, num_y_ff[AccW-1]};
   assign ge_x       = rem_sh_x >= divisor;
   assign ge_y       = rem_sh_y >= divisor;
   assign rem_sub_x  = ge_x ? rem_sh_x - divisor : rem_sh_x;
   assign rem_sub_y  = ge_y ? rem_sh_y - divisor : rem_sh_y;
   assign quo_next_x = {quo_x_ff[AccW-2:0], ge_x};
   assign quo_next_y = {quo_y_ff[AccW-2:0], ge_y};

   // Output slot free when empty or being taken
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign pix_x    = CoordW'(x_acc_ff[AccW-1:FRAC_BITS]);
   assign pix_y    = CoordW'(y_acc_ff[AccW-1:FRAC_BITS]);
   assign pop      = (state_ff == ST_IDLE) && queue_status.valid;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      left_in      = left_ff;
      cnt_in       = cnt_ff;
      steps_in     = steps_ff;
      x_neg_in     = x_neg_ff;
      y_neg_in     = y_neg_ff;
      rem_x_in     = rem_x_ff;
      rem_y_in     = rem_y_ff;
      num_x_in     = num_x_ff;
      num_y_in     = num_y_ff;
      quo_x_in     = quo_x_ff;
      quo_y_in     = quo_y_ff;
      x_acc_in     = x_acc_ff;
      y_acc_in     = y_acc_ff;
      x_inc_in     = x_inc_ff;
      y_inc_in     = y_inc_ff;
      color_in     = color_ff;

      case (state_ff)
         ST_IDLE: begin
            // Load the next line from the queue
            if (queue_status.valid) begin
               x_acc_in = {head_job.x_start[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
               y_acc_in = {head_job.y_start[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
               num_x_in = {head_job.adx[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
               num_y_in = {head_job.ady[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
               rem_x_in = '0;
               rem_y_in = '0;
               quo_x_in = '0;
               quo_y_in = '0;
               cnt_in   = CntW'(AccW - 1);
               steps_in = head_job.steps[COORD_BITS-1:0];
               x_neg_in = head_job.x_neg;
               y_neg_in = head_job.y_neg;
               color_in = head_job.color;
               left_in  = {1'b0, head_job.steps[COORD_BITS-1:0]} + LeftW'(1);
               x_inc_in = '0;
               y_inc_in = '0;
               // A zero-length line skips the division
               if (head_job.steps == '0) begin
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end

         ST_DIVIDE: begin
            // Shift one quotient bit per cycle
            rem_x_in = rem_sub_x[COORD_BITS-1:0];
            rem_y_in = rem_sub_y[COORD_BITS-1:0];
            num_x_in = {num_x_ff[AccW-2:0], 1'b0};
            num_y_in = {num_y_ff[AccW-2:0], 1'b0};
            quo_x_in = quo_next_x;
            quo_y_in = quo_next_y;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               // Apply the direction to the truncated quotients
               x_inc_in = x_neg_ff ? {IncW{1'b0}} - {1'b0, quo_next_x[FRAC_BITS:0]}
                                   : {1'b0, quo_next_x[FRAC_BITS:0]};
               y_inc_in = y_neg_ff ? {IncW{1'b0}} - {1'b0, quo_next_y[FRAC_BITS:0]}
                                   : {1'b0, quo_next_y[FRAC_BITS:0]};
               state_in = ST_RUN;
            end
         end

         ST_RUN: begin
            // Emit the current pixel, then advance the position
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {color_ff, pix_y, pix_x};
               rsp_last_in  = left_ff == LeftW'(1);
               x_acc_in     = x_acc_ff + {{(AccW-IncW){x_inc_ff[IncW-1]}}, x_inc_ff};
               y_acc_in     = y_acc_ff + {{(AccW-IncW){y_inc_ff[IncW-1]}}, y_inc_ff};
               left_in      = left_ff - 1'b1;
               if (left_ff == LeftW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_last_ff  <= rsp_last_in;
         left_ff      <= left_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      steps_ff <= steps_in;
      x_neg_ff <= x_neg_in;
      y_neg_ff <= y_neg_in;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      num_x_ff <= num_x_in;
      num_y_ff <= num_y_in;
      quo_x_ff <= quo_x_in;
      quo_y_ff <= quo_y_in;
      x_acc_ff <= x_acc_in;
      y_acc_ff <= y_acc_in;
      x_inc_ff <= x_inc_in;
      y_inc_ff <= y_inc_in;
      color_ff <= color_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/dda_line_rasterizer.sv =====
// Top level of the DDA line rasterizer: front end, line queue and pixel back end.
//
//  channel | direction | transaction      | payload
//  req_    | in        | one line request | tdata: x_start, y_start, x_end, y_end, line_color
//  rsp_    | out       | one pixel        | tdata: pixel_x, pixel_y, pixel_color; tlast
//
// A line is loaded from the queue, divided in the shared-divisor restoring divider
// (skipped for a zero-length line), then walked one pixel at a time, steps+1 pixels
// in all, held while rsp_ stalls; the divider sets the start-up of each line.
// Requests are taken while the two-entry queue has room, also while the back end runs.
// Reset is synchronous and empties the queue and the output register.
// A stalled rsp_ holds the pixel and the back end; the front keeps filling the queue.
module dda_line_rasterizer
   import dda_lr_pkg::*;
#(
   parameter int COORD_BITS = 6,
   parameter int FRAC_BITS  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,  // x_start, y_start, x_end, y_end, line_color, 0
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,  // pixel_x, pixel_y, pixel_color
   output logic                rsp_tlast
);

   queue_status_type queue_status;
   line_job_type     push_job;
   line_job_type     head_job;
   logic             push;
   logic             pop;

   // Classify requests
   dda_lr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .queue_status (queue_status),
      .push         (push),
      .job          (push_job)
   );

   // Decouple front and back
   dda_lr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   // Divide and walk the line
   dda_lr_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

// ===== src/dda_lr_checker.sv =====
// Port-level checks of the DDA line rasterizer, bound to the top level.
module dda_lr_checker
   import dda_lr_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspDataW-1:0] rsp_tdata,
   input logic                rsp_tlast
);

   logic              req_fire;
   logic              rsp_fire;
   logic [2:0]        pending_ff;
   logic [2:0]        pending_in;
   logic              in_run_ff;
   logic [ColorW-1:0] run_color_ff;
   logic [CoordW-1:0] prev_x_ff;
   logic [CoordW-1:0] prev_y_ff;
   logic [CoordW-1:0] cur_x;
   logic [CoordW-1:0] cur_y;
   logic [ColorW-1:0] cur_color;
   logic [CoordW:0]   diff_x;
   logic [CoordW:0]   diff_y;
   logic              near_x;
   logic              near_y;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign cur_x     = rsp_tdata[CoordW-1:0];
   assign cur_y     = rsp_tdata[2*CoordW-1:CoordW];
   assign cur_color = rsp_tdata[2*CoordW+ColorW-1:2*CoordW];
   assign diff_x    = {1'b0, cur_x} - {1'b0, prev_x_ff};
   assign diff_y    = {1'b0, cur_y} - {1'b0, prev_y_ff};
   assign near_x    = (diff_x == '0) || (diff_x == (CoordW+1)'(1)) || (diff_x == '1);
   assign near_y    = (diff_y == '0) || (diff_y == (CoordW+1)'(1)) || (diff_y == '1);

   // Count lines accepted but not yet finished
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !(rsp_fire && rsp_tlast)) begin
         pending_in = pending_ff + 1'b1;
      end else if (!req_fire && rsp_fire && rsp_tlast) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         in_run_ff  <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         if (rsp_fire) begin
            in_run_ff <= !rsp_tlast;
         end
      end
   end

   // Track the last pixel of the current run
   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         run_color_ff <= cur_color;
         prev_x_ff    <= cur_x;
         prev_y_ff    <= cur_y;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled pixel changed");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != '0)
      else $error("pixel without an open line");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> pending_ff <= 3'd3)
      else $error("more lines taken than the queue can hold");

   a_run_color: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && in_run_ff |-> cur_color == run_color_ff)
      else $error("colour changed inside a run");

   a_run_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && in_run_ff |-> near_x && near_y)
      else $error("pixel run jumped by more than one");

endmodule

bind dda_line_rasterizer dda_lr_checker u_checker (.*);

// ===== test/tb_dda_line_rasterizer.sv =====
// Self-checking testbench for the DDA line rasterizer: line requests in, checked pixel runs out.
module tb_dda_line_rasterizer;
   timeunit 1ns;
   timeprecision 1ps;
   import dda_lr_pkg::*;

   localparam int FracBits    = 16;
   localparam int AccW        = CoordW + FracBits;
   localparam int IncW        = FracBits + 2;
   localparam int RandomLines = 195;
   localparam int DrainCycles = 120;
   localparam int MaxReported = 10;

   // One predicted pixel of a run
   typedef struct packed {
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [ColorW-1:0] color;
      logic              last;
   } pixel_type;

   // Predicts the pixel run of each accepted line and checks the pixels that come out
   class line_pixel_tracker;
      pixel_type pending_pixels[$];
      int        mismatches;

      function new();
         mismatches = 0;
      endfunction

      // signed delta / steps, truncated toward zero, as an IncW-bit two's complement value
      function logic [IncW-1:0] step_increment(logic [CoordW-1:0] from, logic [CoordW-1:0] to,
                                               logic [CoordW-1:0] steps);
         logic [CoordW-1:0] delta;
         logic [AccW-1:0]   quot;
         delta = (to < from) ? from - to : to - from;
         quot  = {delta, {FracBits{1'b0}}} / AccW'(steps);
         if (to < from)
            quot = -quot;
         return quot[IncW-1:0];
      endfunction

      // Note an accepted line: queue every pixel of its run
      function void take_line(logic [CoordW-1:0] xs, logic [CoordW-1:0] ys,
                              logic [CoordW-1:0] xe, logic [CoordW-1:0] ye,
                              logic [ColorW-1:0] color);
         logic [CoordW-1:0] adx, ady, steps;
         logic [AccW-1:0]   x_pos, y_pos;
         logic [IncW-1:0]   x_inc, y_inc;
         pixel_type         p;
         adx   = (xe >= xs) ? xe - xs : xs - xe;
         ady   = (ye >= ys) ? ye - ys : ys - ye;
         steps = (adx > ady) ? adx : ady;
         x_pos = {xs, {FracBits{1'b0}}};
         y_pos = {ys, {FracBits{1'b0}}};
         // a zero-length line has no division and no stepping
         x_inc = (steps == 0) ? '0 : step_increment(xs, xe, steps);
         y_inc = (steps == 0) ? '0 : step_increment(ys, ye, steps);
         for (int i = 0; i <= int'(steps); i++) begin
            if (i != 0) begin
               x_pos = x_pos + {{(AccW-IncW){x_inc[IncW-1]}}, x_inc};
               y_pos = y_pos + {{(AccW-IncW){y_inc[IncW-1]}}, y_inc};
            end
            p.x     = x_pos[AccW-1:FracBits];
            p.y     = y_pos[AccW-1:FracBits];
            p.color = color;
            p.last  = (i == int'(steps));
            pending_pixels.push_back(p);
         end
      endfunction

      function void report(string what, pixel_type want, pixel_type got);
         mismatches++;
         if (mismatches <= MaxReported)
            $display({"%0t: %s: expected x=%0d y=%0d color=%0d last=%0b, ",
                      "got x=%0d y=%0d color=%0d last=%0b"},
                     $time, what, want.x, want.y, want.color, want.last,
                     got.x, got.y, got.color, got.last);
      endfunction

      // Check one accepted pixel against the oldest prediction
      function void check_pixel(pixel_type got);
         pixel_type want;
         if (pending_pixels.size() == 0) begin
            report("pixel with none predicted", '0, got);
            return;
         end
         want = pending_pixels.pop_front();
         if (want.x !== got.x || want.y !== got.y || want.color !== got.color ||
             want.last !== got.last)
            report("pixel mismatch", want, got);
      endfunction

      function int outstanding();
         return pending_pixels.size();
      endfunction

      function bit clean();
         return mismatches == 0 && pending_pixels.size() == 0;
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tlast;

   line_pixel_tracker book;
   bit                req_calm;
   bit                rsp_calm;

   dda_line_rasterizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Draw an idle count; now and then swap between busy and quiet stretches
   function automatic int draw_wait(inout bit calm, input int flip_odds);
      if ($urandom_range(0, flip_odds) == 0)
         calm = !calm;
      return calm ? 0 : int'($urandom_range(0, 11));
   endfunction

   function automatic logic [CoordW-1:0] clamp_coord(int v);
      if (v < 0)
         return '0;
      if (v > 63)
         return 6'd63;
      return v[CoordW-1:0];
   endfunction

   // Offer one line request and hold it until the transaction completes
   task automatic send_line(input logic [CoordW-1:0] xs, input logic [CoordW-1:0] ys,
                            input logic [CoordW-1:0] xe, input logic [CoordW-1:0] ye,
                            input logic [ColorW-1:0] color);
      int gap;
      gap = draw_wait(req_calm, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {{(ReqDataW - 4*CoordW - ColorW){1'b0}}, color, ye, xe, ys, xs};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      book.take_line(xs, ys, xe, ye, color);
   endtask

   // Random line: mostly full-range, some short, a few zero-length
   task automatic random_line();
      int kind, xs, ys, xe, ye;
      kind = $urandom_range(0, 9);
      xs   = $urandom_range(0, 63);
      ys   = $urandom_range(0, 63);
      if (kind == 0) begin
         xe = xs;
         ye = ys;
      end else if (kind <= 3) begin
         xe = int'($urandom_range(0, 12)) - 6 + xs;
         ye = int'($urandom_range(0, 12)) - 6 + ys;
      end else begin
         xe = $urandom_range(0, 63);
         ye = $urandom_range(0, 63);
      end
      send_line(clamp_coord(xs), clamp_coord(ys), clamp_coord(xe), clamp_coord(ye),
                4'($urandom_range(0, 15)));
   endtask

   // Stimulus and end of run
   initial begin
      book       = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero-length lines at both corners
      send_line(6'd0, 6'd0, 6'd0, 6'd0, 4'd0);
      send_line(6'd63, 6'd63, 6'd63, 6'd63, 4'd15);
      // full-length axis lines in both directions
      send_line(6'd0, 6'd0, 6'd63, 6'd0, 4'd1);
      send_line(6'd63, 6'd0, 6'd0, 6'd0, 4'd2);
      send_line(6'd0, 6'd0, 6'd0, 6'd63, 4'd4);
      send_line(6'd0, 6'd63, 6'd0, 6'd0, 4'd8);
      // diagonals
      send_line(6'd0, 6'd0, 6'd63, 6'd63, 4'd5);
      send_line(6'd63, 6'd63, 6'd0, 6'd0, 4'd10);
      send_line(6'd63, 6'd0, 6'd0, 6'd63, 4'd3);
      send_line(6'd0, 6'd63, 6'd63, 6'd0, 4'd12);
      // truncated increments that stop short of the end point
      send_line(6'd0, 6'd0, 6'd63, 6'd62, 4'd6);
      send_line(6'd0, 6'd0, 6'd62, 6'd63, 4'd9);
      send_line(6'd0, 6'd0, 6'd3, 6'd1, 4'd7);
      send_line(6'd63, 6'd63, 6'd60, 6'd62, 4'd11);
      // steep, shallow and one-step lines
      send_line(6'd10, 6'd20, 6'd13, 6'd40, 4'd13);
      send_line(6'd40, 6'd5, 6'd1, 6'd7, 4'd14);
      send_line(6'd5, 6'd5, 6'd6, 6'd6, 4'd15);
      send_line(6'd33, 6'd17, 6'd32, 6'd17, 4'd0);

      repeat (RandomLines) random_line();
      req_tvalid <= 1'b0;

      // drain every predicted pixel, then watch for strays
      while (book.outstanding() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (book.clean())
         $display("tb_dda_line_rasterizer: clean");
      else
         $display("tb_dda_line_rasterizer: errors");
      $finish;
   end

   // Pixel sink: stall at random, check each completed transaction
   initial begin
      pixel_type got;
      int        stall;
      forever begin
         stall = draw_wait(rsp_calm, 40);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1 || reset !== 1'b0);
         got.x     = rsp_tdata[CoordW-1:0];
         got.y     = rsp_tdata[2*CoordW-1:CoordW];
         got.color = rsp_tdata[2*CoordW+ColorW-1:2*CoordW];
         got.last  = rsp_tlast;
         book.check_pixel(got);
      end
   end

   // Hang guard
   initial begin
      #4_000_000;
      $display("tb_dda_line_rasterizer: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
src/dda_lr_pkg.sv
src/dda_lr_front.sv
src/dda_lr_queue.sv
src/dda_lr_back.sv
src/dda_line_rasterizer.sv
src/dda_lr_checker.sv
test/tb_dda_line_rasterizer.sv
